// ===== sv/ipav_pkg.sv =====
// ----------------------------------------------------------------------------
// ipav_pkg
// Shared types and codes for the pool-adjacent-violators isotonic fit block.
// ----------------------------------------------------------------------------
package ipav_pkg;

  // Main sequencer states, one-hot.
  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_PUSH  = 8'b0000_0010,
    ST_RDTOP = 8'b0000_0100,
    ST_MUL   = 8'b0000_1000,
    ST_CMP   = 8'b0001_0000,
    ST_ORD   = 8'b0010_0000,
    ST_DIV   = 8'b0100_0000,
    ST_EMIT  = 8'b1000_0000
  } ipav_state_t;

  // Error flag bit positions.
  localparam int unsigned ERR_ORDER = 0;
  localparam int unsigned ERR_OVFL  = 1;

endpackage

// ===== sv/ipav_ram.sv =====
// ----------------------------------------------------------------------------
// ipav_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ipav_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/ipav_div.sv =====
// ----------------------------------------------------------------------------
// ipav_div
// Restoring divider, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module ipav_div #(
  parameter int NW = 23,
  parameter int DW = 7
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [NW-1:0] num,
  input  logic [DW-1:0]        den,
  output logic                 done,
  output logic signed [NW-1:0] quot
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q_r, q_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          neg_r, neg_nxt;
  logic          run_r, run_nxt;
  logic          done_r, done_nxt;
  logic [DW:0]   trial;

  assign trial = {rem_r[DW-1:0], q_r[NW-1]};

  // Shift-subtract iteration on the magnitude.
  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      neg_nxt = num[NW-1];
      q_nxt   = num[NW-1] ? (~num + 1'b1) : num;
      rem_nxt = '0;
      cnt_nxt = CW'(NW);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (trial >= {1'b0, den}) begin
        rem_nxt = trial - {1'b0, den};
        q_nxt   = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
  end

  assign done = done_r;
  assign quot = neg_r ? $signed(~q_r + 1'b1) : $signed(q_r);

endmodule

// ===== sv/isotonic_pool_adjacent_violators.sv =====
// ----------------------------------------------------------------------------
// isotonic_pool_adjacent_violators
// Streaming isotonic regression by pooling adjacent violators.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. A point that continues
// the pending group leaves the block idle; a point that closes a group runs
// pooling steps (stack read, cross multiply, compare) in turn, as the
// group stack lives in a one-port-read memory. On the final item the block
// emits one result per stored point, strobed by out_valid for one cycle each.
// Every point passes through the key read and the emit, and the first point
// of each group also waits on a serial divider. The
// receiver cannot stall: every out_valid cycle delivers a result.
module isotonic_pool_adjacent_violators #(
  parameter int MAX_POINTS = 64,
  parameter int X_WIDTH    = 16,
  parameter int Y_WIDTH    = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [X_WIDTH-1:0]        in_x_key,
  input  logic signed [Y_WIDTH-1:0] in_y_value,
  input  logic                      in_is_last,
  output logic                      out_valid,
  output logic [X_WIDTH-1:0]        out_x_key_out,
  output logic signed [Y_WIDTH-1:0] out_fitted_value,
  output logic                      out_last_of_run,
  output logic                      out_order_error,
  output logic                      out_overflow_error
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int SW = Y_WIDTH + CW;
  localparam int PW = SW + CW;

  ipav_pkg::ipav_state_t st_r, st_nxt;

  logic [CW-1:0]         depth_r, depth_nxt;
  logic [CW-1:0]         nstore_r, nstore_nxt;
  logic [X_WIDTH-1:0]    pkey_r, pkey_nxt;
  logic signed [SW-1:0]  psum_r, psum_nxt;
  logic [CW-1:0]         pcnt_r, pcnt_nxt;
  logic [1:0]            err_r, err_nxt;
  logic                  fin_r, fin_nxt;
  // Top-of-stack working copy, kept in registers.
  logic signed [SW-1:0]  tsum_r, tsum_nxt;
  logic [CW-1:0]         tcnt_r, tcnt_nxt;
  logic signed [PW-1:0]  pl_r, pr_r;
  // Output walk.
  logic [CW-1:0]         g_r, g_nxt, p_r, p_nxt, used_r, used_nxt;
  logic signed [Y_WIDTH-1:0] mean_r, mean_nxt;
  logic                  newg_r, newg_nxt;

  logic                  k_we, g_we;
  logic [AW-1:0]         k_wa, k_ra, g_wa, g_ra;
  logic [X_WIDTH-1:0]    k_rd;
  logic [SW+CW-1:0]      g_wd, g_rd;
  logic signed [SW-1:0]  bsum;
  logic [CW-1:0]         bcnt;
  logic                  div_go, div_done;
  logic signed [SW-1:0]  div_q;
  logic                  take, in_ord, in_full;
  logic signed [SW-1:0]  yext;

  assign bsum = $signed(g_rd[SW+CW-1:CW]);
  assign bcnt = g_rd[CW-1:0];
  assign yext = SW'(in_y_value);

  ipav_ram #(.WIDTH(X_WIDTH), .DEPTH(MAX_POINTS)) u_keys (
    .clk(clk), .we(k_we), .waddr(k_wa), .wdata(in_x_key), .raddr(k_ra), .rdata(k_rd)
  );

  ipav_ram #(.WIDTH(SW + CW), .DEPTH(MAX_POINTS)) u_groups (
    .clk(clk), .we(g_we), .waddr(g_wa), .wdata(g_wd), .raddr(g_ra), .rdata(g_rd)
  );

  ipav_div #(.NW(SW), .DW(CW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_go), .num(bsum), .den(bcnt),
    .done(div_done), .quot(div_q)
  );

  assign busy   = (st_r != ipav_pkg::ST_IDLE);
  assign take   = start && !busy;
  assign in_ord = (pcnt_r != '0) && (in_x_key < pkey_r);
  assign in_full = nstore_r >= CW'(MAX_POINTS);

  // Products are registered before the compare.
  always_ff @(posedge clk) begin
    pl_r <= PW'(tsum_r) * $signed({1'b0, bcnt});
    pr_r <= PW'(bsum) * $signed({1'b0, tcnt_r});
  end

  // Sequencer.
  always_comb begin
    st_nxt = st_r; depth_nxt = depth_r; nstore_nxt = nstore_r;
    pkey_nxt = pkey_r; psum_nxt = psum_r; pcnt_nxt = pcnt_r; err_nxt = err_r;
    fin_nxt = fin_r; tsum_nxt = tsum_r; tcnt_nxt = tcnt_r;
    g_nxt = g_r; p_nxt = p_r; used_nxt = used_r; mean_nxt = mean_r; newg_nxt = newg_r;
    k_we = 1'b0; k_wa = nstore_r[AW-1:0]; k_ra = p_r[AW-1:0];
    g_we = 1'b0; g_wa = depth_r[AW-1:0]; g_wd = {tsum_r, tcnt_r};
    g_ra = AW'(depth_r - 1'b1);
    div_go = 1'b0;
    out_valid = 1'b0;
    unique case (st_r)
      ipav_pkg::ST_IDLE: begin
        if (take) begin
          fin_nxt = in_is_last;
          if (in_ord) begin
            err_nxt[ipav_pkg::ERR_ORDER] = 1'b1;
          end else if (in_full) begin
            err_nxt[ipav_pkg::ERR_OVFL] = 1'b1;
          end else begin
            k_we = 1'b1;
            nstore_nxt = nstore_r + 1'b1;
            if (pcnt_r != '0 && in_x_key == pkey_r) begin
              psum_nxt = psum_r + yext;
              pcnt_nxt = pcnt_r + 1'b1;
            end else begin
              // Old pending group moves to the top register to be pushed.
              tsum_nxt = psum_r; tcnt_nxt = pcnt_r;
              pkey_nxt = in_x_key; psum_nxt = yext; pcnt_nxt = CW'(1);
              if (pcnt_r != '0) begin
                st_nxt = ipav_pkg::ST_RDTOP;
                fin_nxt = 1'b0;
              end
              if (pcnt_r != '0) fin_nxt = in_is_last;
            end
          end
          if (in_is_last && st_nxt == ipav_pkg::ST_IDLE) begin
            st_nxt = ipav_pkg::ST_PUSH;
          end
        end
      end
      ipav_pkg::ST_PUSH: begin
        // Final push of the pending group.
        fin_nxt = 1'b0;
        tsum_nxt = psum_r; tcnt_nxt = pcnt_r;
        pcnt_nxt = '0;
        if (pcnt_r != '0) begin
          st_nxt = ipav_pkg::ST_RDTOP;
        end else begin
          st_nxt = ipav_pkg::ST_ORD;
        end
      end
      ipav_pkg::ST_RDTOP: begin
        // Read the group below the top register.
        if (depth_r == '0) begin
          g_we = 1'b1; depth_nxt = depth_r + 1'b1;
          st_nxt = fin_r ? ipav_pkg::ST_PUSH : (pcnt_r == '0 ? ipav_pkg::ST_ORD
                                                                : ipav_pkg::ST_IDLE);
        end else begin
          st_nxt = ipav_pkg::ST_MUL;
        end
      end
      ipav_pkg::ST_MUL: begin
        st_nxt = ipav_pkg::ST_CMP;
      end
      ipav_pkg::ST_CMP: begin
        if (pl_r < pr_r) begin
          tsum_nxt = tsum_r + bsum; tcnt_nxt = tcnt_r + bcnt;
          depth_nxt = depth_r - 1'b1;
          st_nxt = ipav_pkg::ST_RDTOP;
        end else begin
          g_we = 1'b1; depth_nxt = depth_r + 1'b1;
          st_nxt = fin_r ? ipav_pkg::ST_PUSH : (pcnt_r == '0 ? ipav_pkg::ST_ORD
                                                                : ipav_pkg::ST_IDLE);
        end
      end
      ipav_pkg::ST_ORD: begin
        // Start of output walk, or a run with nothing stored.
        if (nstore_r == '0) begin
          st_nxt = ipav_pkg::ST_IDLE;
          err_nxt = '0; depth_nxt = '0; pkey_nxt = '0; psum_nxt = '0; pcnt_nxt = '0;
        end else begin
          g_ra = g_r[AW-1:0];
          st_nxt = ipav_pkg::ST_DIV;
          newg_nxt = (used_r == '0);
        end
      end
      ipav_pkg::ST_DIV: begin
        g_ra = g_r[AW-1:0];
        if (newg_r) begin
          div_go = 1'b1; newg_nxt = 1'b0;
        end else if (div_done || used_r != '0) begin
          if (div_done) mean_nxt = div_q[Y_WIDTH-1:0];
          st_nxt = ipav_pkg::ST_EMIT;
        end
      end
      ipav_pkg::ST_EMIT: begin
        g_ra = g_r[AW-1:0];
        out_valid = 1'b1;
        p_nxt = p_r + 1'b1;
        if (used_r + 1'b1 >= bcnt) begin
          used_nxt = '0; g_nxt = g_r + 1'b1;
        end else begin
          used_nxt = used_r + 1'b1;
        end
        if (p_r + 1'b1 == nstore_r) begin
          st_nxt = ipav_pkg::ST_IDLE;
          err_nxt = '0; depth_nxt = '0; nstore_nxt = '0; pkey_nxt = '0;
          psum_nxt = '0; pcnt_nxt = '0; g_nxt = '0; p_nxt = '0; used_nxt = '0;
        end else begin
          st_nxt = ipav_pkg::ST_ORD;
        end
      end
      default: st_nxt = ipav_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ipav_pkg::ST_IDLE;
      depth_r <= '0; nstore_r <= '0; pkey_r <= '0; psum_r <= '0; pcnt_r <= '0;
      err_r <= '0; fin_r <= 1'b0; g_r <= '0; p_r <= '0; used_r <= '0;
      newg_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      depth_r <= depth_nxt; nstore_r <= nstore_nxt; pkey_r <= pkey_nxt;
      psum_r <= psum_nxt; pcnt_r <= pcnt_nxt; err_r <= err_nxt; fin_r <= fin_nxt;
      g_r <= g_nxt; p_r <= p_nxt; used_r <= used_nxt; newg_r <= newg_nxt;
    end
    tsum_r <= tsum_nxt; tcnt_r <= tcnt_nxt; mean_r <= mean_nxt;
  end

  assign out_x_key_out      = k_rd;
  assign out_fitted_value   = mean_r;
  assign out_last_of_run    = (p_r + 1'b1 == nstore_r);
  assign out_order_error    = err_r[ipav_pkg::ERR_ORDER];
  assign out_overflow_error = err_r[ipav_pkg::ERR_OVFL];

endmodule

// ===== sv/ipav_checker.sv =====
// ----------------------------------------------------------------------------
// ipav_checker
// Port-level checks for the isotonic fit block, bound to the top level.
// ----------------------------------------------------------------------------
module ipav_checker (
  input logic clk,
  input logic rst_n,
  input logic busy,
  input logic out_valid,
  input logic out_last_of_run
);

  // Results appear only while the block is busy.
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result outside busy");

  // After the final result the block returns to idle.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_run |=> !busy) else $error("not idle after last");

  // Two results never come back to back within a run.
  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("back-to-back results");

endmodule

bind isotonic_pool_adjacent_violators ipav_checker u_ipav_checker (
  .clk(clk), .rst_n(rst_n), .busy(busy),
  .out_valid(out_valid), .out_last_of_run(out_last_of_run)
);

// ===== bench/isotonic_pool_adjacent_violators_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// isotonic_pool_adjacent_violators_test
// Drives runs of points into the isotonic fit block. A scoreboard predicts
// the fitted results of each run and compares every emitted result with them.
// ----------------------------------------------------------------------------

// Scoreboard: holds the predicted fit state and the queue of fitted results.
class ipav_fit_board;
  localparam int DEPTH = 64;

  typedef struct {
    logic [15:0]        key;
    logic signed [15:0] mean;
    logic               last;
    logic               ord_err;
    logic               ovf_err;
  } fit_point_t;

  fit_point_t         fitted_q[$];
  logic [15:0]        keys[DEPTH];
  longint             sums[DEPTH];
  int                 counts[DEPTH];
  int                 depth;
  logic [15:0]        pend_key;
  longint             pend_sum;
  int                 pend_count;
  int                 stored;
  logic [1:0]         flags;
  int                 errors;

  function new();
    errors = 0;
    clear_run();
  endfunction

  function void clear_run();
    depth = 0;
    pend_key = '0;
    pend_sum = 0;
    pend_count = 0;
    stored = 0;
    flags = '0;
  endfunction

  // Push a finished group, then pool while the top mean is below its neighbor.
  function void push_group(longint sum, int count);
    int t;
    if (count == 0 || depth >= DEPTH) return;
    sums[depth] = sum;
    counts[depth] = count;
    depth++;
    while (depth >= 2) begin
      t = depth - 1;
      if (sums[t] * counts[t-1] < sums[t-1] * counts[t]) begin
        sums[t-1] += sums[t];
        counts[t-1] += counts[t];
        depth--;
      end else begin
        break;
      end
    end
  endfunction

  // Note one accepted item; on the final item queue the whole fit.
  function void note_point(logic [15:0] key, logic signed [15:0] y, logic last);
    int g;
    int used;
    fit_point_t fp;
    if (pend_count > 0 && key < pend_key) begin
      flags[ipav_pkg::ERR_ORDER] = 1'b1;
    end else if (stored >= DEPTH) begin
      flags[ipav_pkg::ERR_OVFL] = 1'b1;
    end else begin
      keys[stored] = key;
      stored++;
      if (pend_count > 0 && key == pend_key) begin
        pend_sum += y;
        pend_count++;
      end else begin
        push_group(pend_sum, pend_count);
        pend_key = key;
        pend_sum = y;
        pend_count = 1;
      end
    end
    if (!last) return;
    push_group(pend_sum, pend_count);
    g = 0;
    used = 0;
    for (int p = 0; p < stored; p++) begin
      fp.key = keys[p];
      fp.mean = (g < depth) ? 16'(sums[g] / counts[g]) : '0;
      fp.last = (p + 1 == stored);
      fp.ord_err = flags[ipav_pkg::ERR_ORDER];
      fp.ovf_err = flags[ipav_pkg::ERR_OVFL];
      fitted_q.push_back(fp);
      used++;
      if (g < depth && used >= counts[g]) begin
        g++;
        used = 0;
      end
    end
    clear_run();
  endfunction

  // Compare one emitted result with the oldest fitted point.
  function void check_point(logic [15:0] key, logic signed [15:0] mean, logic last,
                            logic ord_err, logic ovf_err);
    fit_point_t fp;
    if (fitted_q.size() == 0) begin
      $error("unexpected result: key %0d value %0d", key, mean);
      errors++;
      return;
    end
    fp = fitted_q.pop_front();
    if (key !== fp.key) begin
      $error("x_key_out: expected %0d, got %0d", fp.key, key);
      errors++;
    end
    if (mean !== fp.mean) begin
      $error("fitted_value: expected %0d, got %0d", fp.mean, mean);
      errors++;
    end
    if (last !== fp.last) begin
      $error("last_of_run: expected %0b, got %0b", fp.last, last);
      errors++;
    end
    if (ord_err !== fp.ord_err) begin
      $error("order_error: expected %0b, got %0b", fp.ord_err, ord_err);
      errors++;
    end
    if (ovf_err !== fp.ovf_err) begin
      $error("overflow_error: expected %0b, got %0b", fp.ovf_err, ovf_err);
      errors++;
    end
  endfunction
endclass

module isotonic_pool_adjacent_violators_test;
  localparam int CYCLE_LIMIT = 400000;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [15:0]        in_x_key;
  logic signed [15:0] in_y_value;
  logic               in_is_last;
  logic               out_valid;
  logic [15:0]        out_x_key_out;
  logic signed [15:0] out_fitted_value;
  logic               out_last_of_run;
  logic               out_order_error;
  logic               out_overflow_error;

  ipav_fit_board board;
  int            idle_pct;
  int            cycles;
  int            items_sent;

  isotonic_pool_adjacent_violators dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_x_key(in_x_key), .in_y_value(in_y_value), .in_is_last(in_is_last),
    .out_valid(out_valid), .out_x_key_out(out_x_key_out),
    .out_fitted_value(out_fitted_value), .out_last_of_run(out_last_of_run),
    .out_order_error(out_order_error), .out_overflow_error(out_overflow_error)
  );

  // Clock with an 8 ns period.
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Check each strobed result and count cycles toward the timeout.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      board.check_point(out_x_key_out, out_fitted_value, out_last_of_run,
                        out_order_error, out_overflow_error);
    end
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("isotonic_pool_adjacent_violators_test: errors");
      $finish;
    end
  end

  // Offer one item, with a random idle gap first, and hold it until taken.
  // Start stays high after an item is taken; it drops only while idling.
  task automatic send_point(logic [15:0] key, logic signed [15:0] y, logic last);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_x_key <= key;
    in_y_value <= y;
    in_is_last <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_point(key, y, last);
    items_sent++;
  endtask

  // A random run: mostly rising keys with repeats, some broken order.
  task automatic send_run(int len, bit with_noise);
    logic [15:0] key;
    key = 16'($urandom_range(1000));
    for (int i = 0; i < len; i++) begin
      if (with_noise && $urandom_range(9) == 0) begin
        send_point(16'($urandom), 16'($urandom), 1'b0);
      end else begin
        if ($urandom_range(2) != 0) key = key + 16'($urandom_range(40));
        send_point(key, 16'($urandom_range(4000)) - 16'sd2000 + 16'(i * 20),
                   i == len - 1);
      end
    end
    if (with_noise) send_point(key, 16'($urandom), 1'b1);
  endtask

  initial begin
    board = new();
    cycles = 0;
    items_sent = 0;
    idle_pct = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_x_key = '0;
    in_y_value = '0;
    in_is_last = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, pooling, equal keys, single point.
    send_point(16'h0000, 16'sh7fff, 1'b0);
    send_point(16'h0000, 16'sh7fff, 1'b0);
    send_point(16'h0001, -16'sd32768, 1'b0);
    send_point(16'hffff, -16'sd32768, 1'b0);
    send_point(16'hffff, 16'sd5, 1'b1);
    send_point(16'h1234, -16'sd7, 1'b1);
    // Out-of-order point, then one that also ends the run.
    send_point(16'h0100, 16'sd10, 1'b0);
    send_point(16'h0050, 16'sd3, 1'b0);
    send_point(16'h0200, -16'sd3, 1'b0);
    send_point(16'h0010, 16'sd1, 1'b1);
    // Negative means truncated toward zero.
    send_point(16'h0001, -16'sd1, 1'b0);
    send_point(16'h0002, -16'sd2, 1'b1);
    // Storage full: 64 points, an extra dropped, then an end that is dropped.
    for (int i = 0; i < 66; i++)
      send_point(16'(i), 16'($urandom), i == 65);
    // Order and full together.
    for (int i = 0; i < 65; i++)
      send_point(16'(100 + i), 16'($urandom), 1'b0);
    send_point(16'h0000, 16'sd1, 1'b1);

    // Random runs over the four idling phases.
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 0) ? 0 : (ph == 3) ? 34 : 50;
      while (items_sent < 150 + 30 * (ph + 1)) begin
        send_run($urandom_range(1, 12), $urandom_range(3) == 0);
      end
    end
    start <= 1'b0;

    // Drain: results only come after a final item, so wait until all arrived.
    while (board.fitted_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (board.errors == 0 && board.fitted_q.size() == 0) begin
      $display("isotonic_pool_adjacent_violators_test: clean");
    end else begin
      $display("isotonic_pool_adjacent_violators_test: errors");
    end
    $finish;
  end
endmodule

// ===== files.f =====
sv/ipav_pkg.sv
sv/ipav_ram.sv
sv/ipav_div.sv
sv/isotonic_pool_adjacent_violators.sv
sv/ipav_checker.sv
bench/isotonic_pool_adjacent_violators_test.sv
